>>> rtl/core/pdmd_pkg.sv
package pdmd_pkg;

    parameter int CFG_INDEX_W = 3;
    parameter int CFG_DATA_W  = 16;
    parameter int SPEED_W     = 8;
    parameter int GAIN_W      = 16;
    parameter int STEP_W      = 8;
    parameter int PWM_W       = 8;
    parameter int Q_FRAC      = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BASE_SPEED   = 3'd0,
        CFG_GAIN_P       = 3'd1,
        CFG_GAIN_D       = 3'd2,
        CFG_GAIN_I       = 3'd3,
        CFG_PAUSE_PERIOD = 3'd4
    } t_cfg_index;

    parameter logic [SPEED_W-1:0] RST_BASE_SPEED   = 8'd160;
    parameter logic [GAIN_W-1:0]  RST_GAIN_P       = 16'd123;
    parameter logic [GAIN_W-1:0]  RST_GAIN_D       = 16'd2048;
    parameter logic [GAIN_W-1:0]  RST_GAIN_I       = 16'd0;
    parameter logic [STEP_W-1:0]  RST_PAUSE_PERIOD = 8'd26;

    parameter logic [PWM_W-1:0] PWM_FULL = 8'd255;

endpackage

>>> rtl/core/pid_differential_motor_drive.sv
// PID line-following drive for a two-motor robot.
// Input channel: i_in_valid / o_in_stall carry one signed line error per
// transaction. Output channel: o_out_valid / i_out_stall carry results with
// left and right inverted PWM duty, a pause_stop flag and a last flag.
// Each input gives one drive result; every pause_period inputs it is followed
// by a stop result (both duties 0, pause_stop 1). last marks the final result
// of an input.
// An input transaction loads the input register; its drive result then moves
// to the output register. Throughput: one input per cycle while the output is
// not stalled; an input that adds a stop result holds that register longer.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write
// only while idle. Indexes beyond the list are ignored.
// Reset clears the integral, the previous error, the step counter and all
// valid flags, and loads the default register values.
// A stalled output holds its result; o_in_stall rises while the output
// register cannot take a new result and the input register is full.
module pid_differential_motor_drive #(
    parameter int ERROR_BITS    = 13,
    parameter int INTEGRAL_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [ERROR_BITS-1:0]          i_line_error,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [pdmd_pkg::PWM_W-1:0]            o_left_pwm,
    output logic [pdmd_pkg::PWM_W-1:0]            o_right_pwm,
    output logic                                  o_pause_stop,
    output logic                                  o_last,
    input  logic                                  i_cfg_we,
    input  logic [pdmd_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [pdmd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DIFF_W = ERROR_BITS + 1;
    localparam int PW_P   = ERROR_BITS + pdmd_pkg::GAIN_W + 1;
    localparam int PW_D   = DIFF_W + pdmd_pkg::GAIN_W + 1;
    localparam int PW_I   = INTEGRAL_BITS + pdmd_pkg::GAIN_W + 1;
    localparam int ACC_W  = INTEGRAL_BITS + pdmd_pkg::GAIN_W + 3;
    localparam int CORR_W = ACC_W - pdmd_pkg::Q_FRAC;
    localparam int DEM_W  = CORR_W + 2;
    localparam int SUM_W  = INTEGRAL_BITS + 1;

    // configuration
    logic [pdmd_pkg::SPEED_W-1:0] r_base_speed;
    logic [pdmd_pkg::GAIN_W-1:0]  r_gain_p;
    logic [pdmd_pkg::GAIN_W-1:0]  r_gain_d;
    logic [pdmd_pkg::GAIN_W-1:0]  r_gain_i;
    logic [pdmd_pkg::STEP_W-1:0]  r_pause_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_speed   <= pdmd_pkg::RST_BASE_SPEED;
            r_gain_p       <= pdmd_pkg::RST_GAIN_P;
            r_gain_d       <= pdmd_pkg::RST_GAIN_D;
            r_gain_i       <= pdmd_pkg::RST_GAIN_I;
            r_pause_period <= pdmd_pkg::RST_PAUSE_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdmd_pkg::CFG_BASE_SPEED:   r_base_speed   <= i_cfg_data[pdmd_pkg::SPEED_W-1:0];
                pdmd_pkg::CFG_GAIN_P:       r_gain_p       <= i_cfg_data[pdmd_pkg::GAIN_W-1:0];
                pdmd_pkg::CFG_GAIN_D:       r_gain_d       <= i_cfg_data[pdmd_pkg::GAIN_W-1:0];
                pdmd_pkg::CFG_GAIN_I:       r_gain_i       <= i_cfg_data[pdmd_pkg::GAIN_W-1:0];
                pdmd_pkg::CFG_PAUSE_PERIOD: r_pause_period <= i_cfg_data[pdmd_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic r_s1_valid, r_out_valid, r_out_last;
    logic w_out_ready, w_s1_ready, w_in_accept;

    assign w_out_ready = !r_out_valid || (!i_out_stall && r_out_last);
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign o_in_stall  = !w_s1_ready;
    assign w_in_accept = i_in_valid && w_s1_ready;

    // state update at input transaction
    logic signed [ERROR_BITS-1:0]    r_prev_error;
    logic signed [INTEGRAL_BITS-1:0] r_integral;
    logic [pdmd_pkg::STEP_W-1:0]     r_step_count;

    logic signed [SUM_W-1:0]         w_sum;
    logic signed [INTEGRAL_BITS-1:0] n_integral;
    logic signed [DIFF_W-1:0]        w_diff;
    logic [pdmd_pkg::STEP_W-1:0]     w_step_inc;
    logic                            w_stop;

    assign w_sum = SUM_W'(r_integral) + SUM_W'(i_line_error);
    always_comb begin
        if (w_sum[SUM_W-1] == w_sum[SUM_W-2]) begin
            n_integral = w_sum[INTEGRAL_BITS-1:0];
        end else if (w_sum[SUM_W-1]) begin
            n_integral = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
        end else begin
            n_integral = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
        end
    end
    assign w_diff     = DIFF_W'(i_line_error) - DIFF_W'(r_prev_error);
    assign w_step_inc = r_step_count + pdmd_pkg::STEP_W'(1);
    assign w_stop     = (w_step_inc >= r_pause_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error <= '0;
            r_integral   <= '0;
            r_step_count <= '0;
        end else if (w_in_accept) begin
            r_prev_error <= i_line_error;
            r_integral   <= n_integral;
            r_step_count <= w_stop ? '0 : w_step_inc;
        end
    end

    // input register: operands
    logic signed [ERROR_BITS-1:0]    r_s1_err;
    logic signed [DIFF_W-1:0]        r_s1_diff;
    logic signed [INTEGRAL_BITS-1:0] r_s1_integral;
    logic                            r_s1_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_err      <= i_line_error;
            r_s1_diff     <= w_diff;
            r_s1_integral <= n_integral;
            r_s1_stop     <= w_stop;
        end
    end

    // products, correction and duties
    logic signed [PW_P-1:0]    w_pp;
    logic signed [PW_D-1:0]    w_pd;
    logic signed [PW_I-1:0]    w_pi;
    logic signed [ACC_W-1:0]   w_acc, w_acc_adj;
    logic signed [CORR_W-1:0]  w_corr;
    logic signed [DEM_W-1:0]   w_base, w_dem_l, w_dem_r;
    logic [pdmd_pkg::PWM_W-1:0] w_duty_l, w_duty_r;

    assign w_pp = PW_P'(r_s1_err)      * $signed({1'b0, r_gain_p});
    assign w_pd = PW_D'(r_s1_diff)     * $signed({1'b0, r_gain_d});
    assign w_pi = PW_I'(r_s1_integral) * $signed({1'b0, r_gain_i});

    assign w_acc     = ACC_W'(w_pp) + ACC_W'(w_pd) + ACC_W'(w_pi);
    // round toward zero on the Q4.12 shift
    assign w_acc_adj = w_acc[ACC_W-1]
                     ? w_acc + ACC_W'((1 << pdmd_pkg::Q_FRAC) - 1) : w_acc;
    assign w_corr    = w_acc_adj[ACC_W-1:pdmd_pkg::Q_FRAC];
    assign w_base    = DEM_W'($signed({1'b0, r_base_speed}));
    assign w_dem_l   = w_base - DEM_W'(w_corr);
    assign w_dem_r   = w_base + DEM_W'(w_corr);

    assign w_duty_l = (w_dem_l > 0 && w_dem_l < DEM_W'(pdmd_pkg::PWM_FULL))
                    ? pdmd_pkg::PWM_FULL - w_dem_l[pdmd_pkg::PWM_W-1:0] : '0;
    assign w_duty_r = (w_dem_r > 0 && w_dem_r < DEM_W'(pdmd_pkg::PWM_FULL))
                    ? pdmd_pkg::PWM_FULL - w_dem_r[pdmd_pkg::PWM_W-1:0] : '0;

    // output register; a drive result with last low is followed by a stop result
    logic                        r_out_pause;
    logic [pdmd_pkg::PWM_W-1:0]  r_out_left, r_out_right;
    logic                        w_out_take_stop;

    assign w_out_take_stop = r_out_valid && !i_out_stall && !r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (w_out_take_stop) begin
            r_out_valid <= 1'b1;
            r_out_last  <= 1'b1;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
            r_out_last  <= r_s1_valid ? !r_s1_stop : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take_stop) begin
            r_out_left  <= '0;
            r_out_right <= '0;
            r_out_pause <= 1'b1;
        end else if (w_out_ready && r_s1_valid) begin
            r_out_left  <= w_duty_l;
            r_out_right <= w_duty_r;
            r_out_pause <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_left_pwm   = r_out_left;
    assign o_right_pwm  = r_out_right;
    assign o_pause_stop = r_out_pause;
    assign o_last       = r_out_last;

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pause_stop) |-> (o_left_pwm == '0 && o_right_pwm == '0 && o_last))
        else $error("stop result carries nonzero duty or last low");

    a_stop_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> (o_out_valid && o_pause_stop))
        else $error("drive result with last low not followed by stop result");

    a_drive_not_last_no_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_pause_stop)
        else $error("stop result marked not last");

endmodule
